// ===== sv/i4dmv_pkg.sv =====
// Shared types and constants of the int4 dequantizing matrix-vector block.
package i4dmv_pkg;

  localparam int MAX_COLUMNS = 2048;
  localparam int ACT_ADDR_W  = $clog2(MAX_COLUMNS);
  localparam int BANK_DEPTH  = MAX_COLUMNS / 2;
  localparam int BANK_ADDR_W = ACT_ADDR_W - 1;
  localparam int ACT_W       = 16;
  localparam int NIB_W       = 4;
  localparam int PROD_W      = ACT_W + NIB_W;
  localparam int SUM_W       = 32;
  localparam int ROW_W       = 16;
  localparam int LEN_W       = 12;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_WEIGHT = 1'b1;

  typedef struct packed {
    logic             is_load;
    logic             last;
    logic [ROW_W-1:0] row;
  } ctrl_t;

endpackage

// ===== sv/i4dmv_lane.sv =====
// One multiply lane: an activation bank, its registered read and the int4 product.
module i4dmv_lane (
  input  logic                               clk,
  input  logic                               wr_en,
  input  logic [i4dmv_pkg::BANK_ADDR_W-1:0]  wr_addr,
  input  logic [i4dmv_pkg::ACT_W-1:0]        wr_data,
  input  logic                               rd_en,
  input  logic [i4dmv_pkg::BANK_ADDR_W-1:0]  rd_addr,
  input  logic [i4dmv_pkg::NIB_W-1:0]        nibble,
  input  logic                               prod_en,
  output logic [i4dmv_pkg::PROD_W-1:0]       prod
);

  localparam int PROD_W = i4dmv_pkg::PROD_W;

  logic [i4dmv_pkg::ACT_W-1:0] bank [i4dmv_pkg::BANK_DEPTH];
  logic [i4dmv_pkg::ACT_W-1:0] act_q;
  logic [i4dmv_pkg::NIB_W-1:0] nib_q;
  logic signed [i4dmv_pkg::NIB_W-1:0]  weight;
  logic signed [i4dmv_pkg::PROD_W-1:0] prod_next;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      bank[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      act_q <= bank[rd_addr];
      nib_q <= nibble;
    end
  end

  // Flipping the top bit of an offset-8 nibble gives the signed weight.
  assign weight    = $signed({~nib_q[i4dmv_pkg::NIB_W-1], nib_q[i4dmv_pkg::NIB_W-2:0]});
  assign prod_next = PROD_W'(weight) * PROD_W'($signed(act_q));

  always_ff @(posedge clk) begin
    if (prod_en) begin
      prod <= prod_next;
    end
  end

endmodule

// ===== sv/i4dmv_merge.sv =====
// Merge stage: adds both lane products to the row sum and holds the output register.
module i4dmv_merge (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  i4dmv_pkg::ctrl_t                  ctrl,
  input  logic [i4dmv_pkg::PROD_W-1:0]      prod_even,
  input  logic [i4dmv_pkg::PROD_W-1:0]      prod_odd,
  output logic                              take,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // row_sum [31:0], row_number [47:32]
  output logic [47:0]                       m_tdata
);

  localparam int PROD_W = i4dmv_pkg::PROD_W;
  localparam int SUM_W  = i4dmv_pkg::SUM_W;

  logic [SUM_W-1:0]            sum;
  logic [SUM_W-1:0]            total;
  logic [SUM_W-1:0]            out_sum;
  logic [i4dmv_pkg::ROW_W-1:0] out_row;
  logic                        emit;

  assign total = sum
               + {{(SUM_W-PROD_W){prod_even[PROD_W-1]}}, prod_even}
               + {{(SUM_W-PROD_W){prod_odd[PROD_W-1]}}, prod_odd};

  assign take = in_valid && (ctrl.is_load || !ctrl.last || !m_tvalid || m_tready);
  assign emit = take && !ctrl.is_load && ctrl.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      sum      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (take) begin
        if (ctrl.is_load || ctrl.last) begin
          sum <= '0;
        end else begin
          sum <= total;
        end
      end
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_sum <= total;
      out_row <= ctrl.row;
    end
  end

  assign m_tdata = {out_row, out_sum};

endmodule

// ===== sv/int4_dequant_matrix_vector.sv =====
// Top level of the int4 dequantizing matrix-vector block with two column lanes.
//
// The block takes one transfer per cycle, either an activation load or a packed weight
// byte, as long as the result side keeps up; a row result enters the output register
// once its last byte has passed the bank read and the product registers. Activations
// sit in two banks of MAX_COLUMNS/2 entries, even columns in one and odd columns in
// the other, so both nibbles of a byte read their activations in the same cycle and
// two lanes multiply them side by side before one adder folds both products into the
// row sum. While a result waits at the output, items keep flowing until the last byte
// of the next row reaches the merge stage; the input then stalls as soon as the first
// stage holds an item. The store is not cleared after reset: every column that a
// weight uses must be loaded first. The configuration register is always ready and
// should only be written while no item is in flight.
module int4_dequant_matrix_vector (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [11:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  // act_index [10:0], act_value [26:11], weight_byte [34:27], zero [39:35]
  input  logic [39:0] s_tdata,
  // cmd [0]
  input  logic [0:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // row_sum [31:0], row_number [47:32]
  output logic [47:0] m_tdata
);

  localparam int ADDR_W = i4dmv_pkg::ACT_ADDR_W;
  localparam int LEN_W  = i4dmv_pkg::LEN_W;
  localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(i4dmv_pkg::MAX_COLUMNS);
  localparam logic [LEN_W-1:0] LEN_MIN = LEN_W'(2);

  logic [LEN_W-1:0]            columns_in_use;
  logic [LEN_W-1:0]            len_even;
  logic [LEN_W-1:0]            len_eff;
  logic [ADDR_W-1:0]           col;
  logic [i4dmv_pkg::ROW_W-1:0] row;
  logic [LEN_W-1:0]            col_sum;
  logic                        row_end;

  logic [ADDR_W-1:0]           act_index;
  logic [i4dmv_pkg::ACT_W-1:0] act_value;
  logic [7:0]                  weight_byte;
  logic                        cmd;
  logic                        accept;
  logic                        is_weight;

  logic                        v1;
  logic                        v2;
  i4dmv_pkg::ctrl_t            ctrl1;
  i4dmv_pkg::ctrl_t            ctrl2;
  i4dmv_pkg::ctrl_t            ctrl_in;
  logic                        s2_take;
  logic                        s2_free;
  logic                        adv1;
  logic [i4dmv_pkg::PROD_W-1:0] prod_even;
  logic [i4dmv_pkg::PROD_W-1:0] prod_odd;

  assign act_index   = s_tdata[10:0];
  assign act_value   = s_tdata[26:11];
  assign weight_byte = s_tdata[34:27];
  assign cmd         = s_tuser[0];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      columns_in_use <= LEN_CAP;
    end else if (cfg_valid) begin
      columns_in_use <= cfg_data;
    end
  end

  always_comb begin
    len_even = {columns_in_use[LEN_W-1:1], 1'b0};
    if (len_even < LEN_MIN) begin
      len_eff = LEN_MIN;
    end else if (len_even > LEN_CAP) begin
      len_eff = LEN_CAP;
    end else begin
      len_eff = len_even;
    end
  end

  assign s2_free  = !v2 || s2_take;
  assign adv1     = v1 && s2_free;
  assign s_tready = !v1 || s2_free;
  assign accept   = s_tvalid && s_tready;
  assign is_weight = (cmd == i4dmv_pkg::CMD_WEIGHT);

  assign col_sum = LEN_W'(col) + LEN_W'(2);
  assign row_end = (col_sum >= len_eff);

  always_comb begin
    ctrl_in.is_load = !is_weight;
    ctrl_in.last    = is_weight && row_end;
    ctrl_in.row     = row;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (!is_weight) begin
        col <= '0;
        row <= '0;
      end else if (row_end) begin
        col <= '0;
        row <= row + 1'b1;
      end else begin
        col <= col_sum[ADDR_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (accept) begin
        v1 <= 1'b1;
      end else if (adv1) begin
        v1 <= 1'b0;
      end
      if (adv1) begin
        v2 <= 1'b1;
      end else if (s2_take) begin
        v2 <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ctrl1 <= ctrl_in;
    end
    if (adv1) begin
      ctrl2 <= ctrl1;
    end
  end

  i4dmv_lane u_lane_even (
    .clk     (clk),
    .wr_en   (accept && !is_weight && !act_index[0]),
    .wr_addr (act_index[ADDR_W-1:1]),
    .wr_data (act_value),
    .rd_en   (accept && is_weight),
    .rd_addr (col[ADDR_W-1:1]),
    .nibble  (weight_byte[3:0]),
    .prod_en (adv1),
    .prod    (prod_even)
  );

  i4dmv_lane u_lane_odd (
    .clk     (clk),
    .wr_en   (accept && !is_weight && act_index[0]),
    .wr_addr (act_index[ADDR_W-1:1]),
    .wr_data (act_value),
    .rd_en   (accept && is_weight),
    .rd_addr (col[ADDR_W-1:1]),
    .nibble  (weight_byte[7:4]),
    .prod_en (adv1),
    .prod    (prod_odd)
  );

  i4dmv_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v2),
    .ctrl      (ctrl2),
    .prod_even (prod_even),
    .prod_odd  (prod_odd),
    .take      (s2_take),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  // The column position always points at an even column.
  assert property (@(posedge clk) disable iff (rst) col[0] == 1'b0)
    else $error("column position is odd");

  // A load transfer restarts the position at row 0, column 0.
  assert property (@(posedge clk) disable iff (rst)
    (accept && !is_weight) |=> (col == '0 && row == '0))
    else $error("load did not restart the position");

  // The last byte of a row returns the column to zero.
  assert property (@(posedge clk) disable iff (rst)
    (accept && is_weight && row_end) |=> (col == '0))
    else $error("row end did not clear the column");

  // The merge stage only holds an item while a finished row waits at the output.
  assert property (@(posedge clk) disable iff (rst)
    (v2 && !s2_take) |-> (m_tvalid && !m_tready && ctrl2.last))
    else $error("merge stage stalled without an output stall");

endmodule
